// File: hdl/rmslm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rmslm_pkg;

    localparam int NUM_CH     = 4;
    localparam int SAMPLE_W   = 16;
    localparam int RMS_W      = 16;
    localparam int FRAMES_W   = 10;
    localparam int MAX_FRAMES = 512;

    // The count must be able to hold MAX_FRAMES itself.
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);

    // A square of a 16-bit sample is at most 2**30, so it fits in SQ_W - 1 bits,
    // and MAX_FRAMES of them add at most clog2(MAX_FRAMES) bits.
    localparam int SQ_W      = 2 * SAMPLE_W;
    localparam int SUM_W     = SQ_W - 1 + $clog2(MAX_FRAMES);
    localparam int ROOT_IN_W = 2 * RMS_W;
    localparam int RREM_W    = RMS_W + 2;
    localparam int STEP_W    = $clog2(SUM_W);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [RMS_W-1:0]           rms_t;
    typedef logic [CNT_W-1:0]           count_t;

    typedef struct packed {
        logic   load;
        logic   mul;
        logic   acc;
        logic   div_init;
        logic   div_step;
        logic   root_step;
        count_t divisor;
    } lane_ctrl_t;

    typedef struct packed {
        logic   load;
        logic   overrun;
        count_t frames;
    } merge_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/rmslm_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rmslm_in_if;
    logic                    valid;
    logic                    ready;
    rmslm_pkg::sample_t      sample_ch0;
    rmslm_pkg::sample_t      sample_ch1;
    rmslm_pkg::sample_t      sample_ch2;
    rmslm_pkg::sample_t      sample_ch3;
    logic                    last_frame;

    modport source (output valid, output sample_ch0, output sample_ch1,
                    output sample_ch2, output sample_ch3, output last_frame,
                    input ready);
    modport sink   (input valid, input sample_ch0, input sample_ch1,
                    input sample_ch2, input sample_ch3, input last_frame,
                    output ready);
endinterface

interface rmslm_out_if;
    logic                              valid;
    logic                              ready;
    rmslm_pkg::rms_t                   rms_ch0;
    rmslm_pkg::rms_t                   rms_ch1;
    rmslm_pkg::rms_t                   rms_ch2;
    rmslm_pkg::rms_t                   rms_ch3;
    logic [rmslm_pkg::FRAMES_W-1:0]    frames_used;
    logic                              overrun;

    modport source (output valid, output rms_ch0, output rms_ch1, output rms_ch2,
                    output rms_ch3, output frames_used, output overrun,
                    input ready);
    modport sink   (input valid, input rms_ch0, input rms_ch1, input rms_ch2,
                    input rms_ch3, input frames_used, input overrun,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/rmslm_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module rmslm_lane
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rmslm_pkg::sample_t    sample,
    input  wire rmslm_pkg::lane_ctrl_t ctrl,
    output rmslm_pkg::rms_t            root
);

    logic [rmslm_pkg::SAMPLE_W-1:0]  mag_reg,  mag_next;
    logic [rmslm_pkg::SQ_W-1:0]      sq_reg,   sq_next;
    logic [rmslm_pkg::SUM_W-1:0]     sum_reg,  sum_next;
    logic [rmslm_pkg::SUM_W-1:0]     quo_reg,  quo_next;
    rmslm_pkg::count_t               rem_reg,  rem_next;
    rmslm_pkg::rms_t                 root_reg, root_next;
    logic [rmslm_pkg::RREM_W-1:0]    rrem_reg, rrem_next;

    logic [rmslm_pkg::CNT_W:0]       div_trial;
    logic [rmslm_pkg::CNT_W:0]       div_diff;
    logic                            div_ge;
    logic [rmslm_pkg::RREM_W+1:0]    rt_trial_rem;
    logic [rmslm_pkg::RREM_W+1:0]    rt_trial;
    logic [rmslm_pkg::RREM_W+1:0]    rt_diff;
    logic                            rt_ge;

    // Restoring division, one quotient bit per step; the quotient shifts in
    // behind the dividend bits in the same register.
    assign div_trial = {rem_reg, quo_reg[rmslm_pkg::SUM_W-1]};
    assign div_ge    = div_trial >= {1'b0, ctrl.divisor};
    assign div_diff  = div_trial - {1'b0, ctrl.divisor};

    // Digit-by-digit square root, two radicand bits per step.
    assign rt_trial_rem = {rrem_reg, quo_reg[rmslm_pkg::ROOT_IN_W-1 -: 2]};
    assign rt_trial     = {2'b00, root_reg, 2'b01};
    assign rt_ge        = rt_trial_rem >= rt_trial;
    assign rt_diff      = rt_trial_rem - rt_trial;

    always_comb
    begin
        mag_next  = mag_reg;
        sq_next   = sq_reg;
        sum_next  = sum_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        rrem_next = rrem_reg;
        if (ctrl.load)
        begin
            mag_next = sample[rmslm_pkg::SAMPLE_W-1] ? (~sample + 1'b1) : sample;
        end
        if (ctrl.mul)
        begin
            sq_next = mag_reg * mag_reg;
        end
        if (ctrl.acc)
        begin
            sum_next = sum_reg + rmslm_pkg::SUM_W'(sq_reg);
        end
        if (ctrl.div_init)
        begin
            quo_next  = sum_reg;
            sum_next  = '0;
            rem_next  = '0;
            root_next = '0;
            rrem_next = '0;
        end
        if (ctrl.div_step)
        begin
            rem_next = div_ge ? div_diff[rmslm_pkg::CNT_W-1:0]
                              : div_trial[rmslm_pkg::CNT_W-1:0];
            quo_next = {quo_reg[rmslm_pkg::SUM_W-2:0], div_ge};
        end
        if (ctrl.root_step)
        begin
            rrem_next = rt_ge ? rt_diff[rmslm_pkg::RREM_W-1:0]
                              : rt_trial_rem[rmslm_pkg::RREM_W-1:0];
            root_next = {root_reg[rmslm_pkg::RMS_W-2:0], rt_ge};
            quo_next  = {quo_reg[rmslm_pkg::SUM_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        sq_reg   <= sq_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        rrem_reg <= rrem_next;
    end

    assign root = root_reg;

endmodule

`default_nettype wire

// File: hdl/rmslm_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module rmslm_merge
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire rmslm_pkg::rms_t        roots [rmslm_pkg::NUM_CH],
    input  wire rmslm_pkg::merge_ctrl_t ctrl,
    output logic                        free,
    rmslm_out_if.source                 level_out
);

    logic                             valid_reg, valid_next;
    rmslm_pkg::rms_t                  rms_reg [rmslm_pkg::NUM_CH];
    logic [rmslm_pkg::FRAMES_W-1:0]   frames_reg;
    logic                             overrun_reg;

    assign free = !valid_reg || level_out.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.load)
        begin
            valid_next = 1'b1;
        end
        else if (level_out.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int i = 0; i < rmslm_pkg::NUM_CH; i++)
            begin
                rms_reg[i] <= roots[i];
            end
            frames_reg  <= rmslm_pkg::FRAMES_W'(ctrl.frames);
            overrun_reg <= ctrl.overrun;
        end
    end

    assign level_out.valid       = valid_reg;
    assign level_out.rms_ch0     = rms_reg[0];
    assign level_out.rms_ch1     = rms_reg[1];
    assign level_out.rms_ch2     = rms_reg[2];
    assign level_out.rms_ch3     = rms_reg[3];
    assign level_out.frames_used = frames_reg;
    assign level_out.overrun     = overrun_reg;

endmodule

`default_nettype wire

// File: hdl/multichannel_rms_level_meter_unit.sv
// Channel     Direction  Word
// frame_in    in         four signed 16-bit samples and last_frame
// level_out   out        four 16-bit RMS levels, frames_used, overrun
//
// A frame that does not end a block is processed as magnitude, square, accumulate.
// A frame that ends a block then also runs the bit-serial divider and
// the two-bit-per-step square root in each lane.
// All four lanes run in lockstep under one sequencer.
// Reset clears the sums, the frame count, the overrun flag and the output valid.
// The result sits in an output register; a stalled consumer holds the sequencer
// only when the next block result is ready to load.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_rms_level_meter_unit
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    rmslm_in_if.sink    frame_in,
    rmslm_out_if.source level_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_INIT = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_ROOT = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]                     state_reg,   state_next;
    rmslm_pkg::count_t              count_reg,   count_next;
    logic                           overrun_reg, overrun_next;
    logic                           last_reg,    last_next;
    logic                           take_reg,    take_next;
    logic [rmslm_pkg::STEP_W-1:0]   step_reg,    step_next;

    logic                           accept;
    logic                           room;
    logic                           merge_free;
    rmslm_pkg::lane_ctrl_t          lane_ctrl;
    rmslm_pkg::merge_ctrl_t         merge_ctrl;
    rmslm_pkg::sample_t             samples [rmslm_pkg::NUM_CH];
    rmslm_pkg::rms_t                roots   [rmslm_pkg::NUM_CH];

    assign frame_in.ready = (state_reg == S_IDLE);
    assign accept         = frame_in.valid && frame_in.ready;
    assign room           = count_reg < rmslm_pkg::CNT_W'(rmslm_pkg::MAX_FRAMES);

    assign samples[0] = frame_in.sample_ch0;
    assign samples[1] = frame_in.sample_ch1;
    assign samples[2] = frame_in.sample_ch2;
    assign samples[3] = frame_in.sample_ch3;

    always_comb
    begin
        lane_ctrl.load      = accept;
        lane_ctrl.mul       = (state_reg == S_MUL);
        lane_ctrl.acc       = (state_reg == S_ACC) && take_reg;
        lane_ctrl.div_init  = (state_reg == S_INIT);
        lane_ctrl.div_step  = (state_reg == S_DIV);
        lane_ctrl.root_step = (state_reg == S_ROOT);
        lane_ctrl.divisor   = count_reg;

        merge_ctrl.load     = (state_reg == S_OUT) && merge_free;
        merge_ctrl.overrun  = overrun_reg;
        merge_ctrl.frames   = count_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        overrun_next = overrun_reg;
        last_next    = last_reg;
        take_next    = take_reg;
        step_next    = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next  = frame_in.last_frame;
                    take_next  = room;
                    // A full block drops the word and remembers it.
                    if (!room)
                    begin
                        overrun_next = 1'b1;
                    end
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (take_reg)
                begin
                    count_next = count_reg + 1'b1;
                end
                state_next = last_reg ? S_INIT : S_IDLE;
            end
            S_INIT:
            begin
                step_next  = rmslm_pkg::STEP_W'(rmslm_pkg::SUM_W - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (step_reg == '0)
                begin
                    step_next  = rmslm_pkg::STEP_W'(rmslm_pkg::RMS_W - 1);
                    state_next = S_ROOT;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            S_ROOT:
            begin
                if (step_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            S_OUT:
            begin
                if (merge_free)
                begin
                    count_next   = '0;
                    overrun_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            overrun_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            overrun_reg <= overrun_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        take_reg <= take_next;
        step_reg <= step_next;
    end

    for (genvar i = 0; i < rmslm_pkg::NUM_CH; i++)
    begin : g_lane
        rmslm_lane u_lane
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .sample (samples[i]),
            .ctrl   (lane_ctrl),
            .root   (roots[i])
        );
    end

    rmslm_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .roots     (roots),
        .ctrl      (merge_ctrl),
        .free      (merge_free),
        .level_out (level_out)
    );

endmodule

`default_nettype wire

// File: hdl/rmslm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rmslm_checker
(
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire rmslm_pkg::rms_t                rms_ch0,
    input wire rmslm_pkg::rms_t                rms_ch1,
    input wire rmslm_pkg::rms_t                rms_ch2,
    input wire rmslm_pkg::rms_t                rms_ch3,
    input wire logic [rmslm_pkg::FRAMES_W-1:0] frames_used
);

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word withdrawn while stalled");

    // Every block averages at least one frame.
    a_frames_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frames_used != '0)
        else $error("result word reports zero frames");

    // The root of a mean of 16-bit squares never exceeds full scale.
    a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rms_ch0 <= 16'h8000) && (rms_ch1 <= 16'h8000) &&
                      (rms_ch2 <= 16'h8000) && (rms_ch3 <= 16'h8000))
        else $error("RMS level beyond full scale");

    // The sequencer drops ready after it accepts a frame.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on consecutive cycles");

endmodule

bind multichannel_rms_level_meter_unit rmslm_checker u_rmslm_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (frame_in.valid),
    .in_ready    (frame_in.ready),
    .out_valid   (level_out.valid),
    .out_ready   (level_out.ready),
    .rms_ch0     (level_out.rms_ch0),
    .rms_ch1     (level_out.rms_ch1),
    .rms_ch2     (level_out.rms_ch2),
    .rms_ch3     (level_out.rms_ch3),
    .frames_used (level_out.frames_used)
);

`default_nettype wire
